>>> sv/lcd_decimal_number_writer_macros.svh
// assertion helpers for the decimal number writer
`ifndef LCD_DECIMAL_NUMBER_WRITER_MACROS_SVH
`define LCD_DECIMAL_NUMBER_WRITER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LDNW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LDNW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ldnw_pkg.sv
// ----------------------------------------------------------------------------
// ldnw_pkg
// shared constants, types and tables of the decimal number writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ldnw_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam int VALUE_W = 31;
  localparam int COL_W   = 3;
  localparam int ROW_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 4;

  // x / 10 == (x * RECIP) >> RECIP_SHIFT for every x below 2**32
  localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

  localparam logic [BYTE_W-1:0] ROW_BASE [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

  // controller to datapath
  typedef struct packed {
    logic load;        // capture a new item
    logic conv;        // peel off one decimal digit
    logic conv_first;  // first digit step, also sends the position command
    logic emit;        // send one stored digit
  } ldnw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;   // this step leaves no more digits to take
    logic emit_last;   // the digit being sent is the final one
  } ldnw_status_t;

endpackage

`default_nettype wire

>>> sv/ldnw_ctrl.sv
// ----------------------------------------------------------------------------
// ldnw_ctrl
// sequencer: capture, digit extraction, digit output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldnw_ctrl
  import ldnw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire ldnw_status_t status,
  output ldnw_cmd_t         cmd,
  output logic              busy
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIRST = 4'b0010,
    ST_CONV  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd.conv       = 1'b1;
        cmd.conv_first = 1'b1;
        state_next     = status.conv_done ? ST_EMIT : ST_CONV;
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

>>> sv/ldnw_dp.sv
// ----------------------------------------------------------------------------
// ldnw_dp
// datapath: divide by ten, digit store, output byte register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldnw_dp
  import ldnw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ldnw_cmd_t          cmd,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [COL_W-1:0]   column,
  input  wire logic [ROW_W-1:0]   row,
  output ldnw_status_t            status,
  output logic                    strobe,
  output logic                    is_data,
  output logic [BYTE_W-1:0]       bus_byte,
  output logic                    last
);

  logic [VALUE_W-1:0] num;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [CNT_W-1:0]   cnt;
  logic [DIGIT_W-1:0] digits [MAX_DIGITS];

  logic [63:0]        prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_full;
  logic [DIGIT_W-1:0] rem;
  logic [CNT_W-1:0]   cnt_m1;

  // reciprocal multiply for the quotient, shift-add for the remainder
  assign prod     = {33'd0, num} * {32'd0, RECIP};
  assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = num - quot_x10;
  assign rem      = rem_full[DIGIT_W-1:0];
  assign cnt_m1   = cnt - CNT_W'(1);

  assign status.conv_done = (quot == '0) || (cnt == CNT_W'(MAX_DIGITS - 1));
  assign status.emit_last = (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num   <= value;
      col_q <= column;
      row_q <= row;
      cnt   <= '0;
    end else if (cmd.conv) begin
      digits[cnt[IDX_W-1:0]] <= rem;
      num                    <= quot;
      cnt                    <= cnt + CNT_W'(1);
    end else if (cmd.emit) begin
      cnt <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.conv_first | cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_first) begin
      is_data  <= 1'b0;
      bus_byte <= ROW_BASE[row_q] + BYTE_W'(col_q);
      last     <= 1'b0;
    end else if (cmd.emit) begin
      is_data  <= 1'b1;
      bus_byte <= ASCII_ZERO + BYTE_W'(digits[cnt_m1[IDX_W-1:0]]);
      last     <= status.emit_last;
    end
  end

endmodule

`default_nettype wire

>>> sv/lcd_decimal_number_writer.sv
// ----------------------------------------------------------------------------
// lcd_decimal_number_writer
// prints a number in decimal at a text position of a character display
// ----------------------------------------------------------------------------
//
// channel   direction  handshake           payload
// command   in         start & !busy       value[30:0], column[2:0], row[1:0]
// bytes     out        strobe, one cycle   is_data, bus_byte[7:0], last
//
// an item with n decimal digits (n = 1..10) occupies the block for the accept,
// n steps of the divide-by-ten unit (one digit per step, least significant
// first) and n reads of the digit store. the position command leaves in the
// cycle after the first divide step, each digit in the cycle after its read;
// busy drops as the last digit is registered.
// rst is synchronous; it returns the sequencer to idle and clears strobe.
// the receiver cannot stall, so bytes go out at the rate they are produced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lcd_decimal_number_writer_macros.svh"

module lcd_decimal_number_writer
  import ldnw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [COL_W-1:0]   column,
  input  wire logic [ROW_W-1:0]   row,
  output logic                    busy,
  output logic                    strobe,
  output logic                    is_data,
  output logic [BYTE_W-1:0]       bus_byte,
  output logic                    last
);

  // command and status between sequencer and datapath
  ldnw_cmd_t    cmd;
  ldnw_status_t status;

  // sequencer: idle, first digit step with position command, more digit
  // steps, then digit output most significant first
  ldnw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: holds the number, the digit store and the output register
  ldnw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .value    (value),
    .column   (column),
    .row      (row),
    .status   (status),
    .strobe   (strobe),
    .is_data  (is_data),
    .bus_byte (bus_byte),
    .last     (last)
  );

  // the final transfer of an item is always a digit, never the position
  `LDNW_ASSERT_NOW(a_last_is_digit, strobe && last, is_data, "last byte is not a digit")

  // a position command is never the final transfer
  `LDNW_ASSERT_NOW(a_cmd_not_last, strobe && !is_data, !last, "position command marked last")

  // an accepted item always occupies the block in the next cycle
  `LDNW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")

  // the sequencer never captures while busy
  `LDNW_ASSERT_NOW(a_load_idle, cmd.load, !busy, "item captured while busy")

endmodule

`default_nettype wire

>>> dv/tb_lcd_decimal_number_writer.sv
// ----------------------------------------------------------------------------
// tb_lcd_decimal_number_writer
// self-checking bench for the decimal number writer of a character display
// ----------------------------------------------------------------------------
// numbers go in with a text position. Each accepted transfer is expanded here
// into the bytes that the display should receive: one position command
// (row base plus column), then the ascii digits, most significant first, with
// the final byte marked. Every strobed output byte is checked in order against
// that list. The stimulus starts with hand-picked cases: zero, the largest
// value, edges between digit counts, and the corners of the text grid.
// It then runs random numbers of every digit count in bursts with random
// gaps, random numbers over the full 31-bit range, and a back-to-back stretch
// with no gaps at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lcd_decimal_number_writer;
  import ldnw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run
  localparam int SETTLE_TICKS = 40;      // quiet time after the last byte
  localparam int MAX_GAP      = 25;      // longer than one 10-digit item
  localparam int MAX_BURST    = 12;

  // display row start addresses, rows 0..3
  localparam logic [BYTE_W-1:0] ROW_ADDR [4] = '{8'h80, 8'h90, 8'h88, 8'h98};
  localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'd48;

  // one byte as the display bus sees it
  typedef struct {
    logic              is_data;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;
  } display_byte_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic [COL_W-1:0]   column = '0;
  logic [ROW_W-1:0]   row = '0;
  logic               busy;
  logic               strobe;
  logic               is_data;
  logic [BYTE_W-1:0]  bus_byte;
  logic               last;

  display_byte_t pending_bytes[$];  // bytes still owed by the block, in order
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // sender pacing: bursts of transfers separated by random gaps
  bit pace_gaps = 1'b1;
  int burst_left = 0;

  lcd_decimal_number_writer dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .value    (value),
    .column   (column),
    .row      (row),
    .busy     (busy),
    .strobe   (strobe),
    .is_data  (is_data),
    .bus_byte (bus_byte),
    .last     (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // prediction: expand one number into its display bytes
  // --------------------------------------------------------------------------
  function automatic void predict_bytes(input logic [VALUE_W-1:0] num_in,
                                        input logic [COL_W-1:0]   col_in,
                                        input logic [ROW_W-1:0]   row_in);
    logic [BYTE_W-1:0] digit_chars [MAX_DIGITS];
    int unsigned       rest;
    int                ndig;
    display_byte_t     b;
    rest = num_in;
    ndig = 0;
    // peel digits off the low end; zero still yields one digit, and a digit
    // buffer of MAX_DIGITS keeps only the low digits of a longer number
    do begin
      digit_chars[ndig] = DIGIT_ZERO + BYTE_W'(rest % 10);
      rest = rest / 10;
      ndig++;
    end while (rest != 0 && ndig < MAX_DIGITS);
    // position command first: row base plus column, never the last byte
    b.is_data  = 1'b0;
    b.bus_byte = ROW_ADDR[row_in] + BYTE_W'(col_in);
    b.last     = 1'b0;
    pending_bytes.push_back(b);
    // then the digits, most significant first
    for (int i = ndig - 1; i >= 0; i--) begin
      b.is_data  = 1'b1;
      b.bus_byte = digit_chars[i];
      b.last     = (i == 0);
      pending_bytes.push_back(b);
    end
  endfunction

  // --------------------------------------------------------------------------
  // mismatch reporting: one line each, printing capped, counting never capped
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // --------------------------------------------------------------------------
  // output checker: the receiver never stalls, so every strobe is a transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    display_byte_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h (is_data %b last %b) with nothing owed",
                                  bus_byte, is_data, last));
      end else begin
        want = pending_bytes.pop_front();
        if (is_data !== want.is_data)
          report_mismatch($sformatf("is_data %b, wanted %b (byte %02h)",
                                    is_data, want.is_data, want.bus_byte));
        if (bus_byte !== want.bus_byte)
          report_mismatch($sformatf("bus_byte %02h, wanted %02h",
                                    bus_byte, want.bus_byte));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, wanted %b (byte %02h)",
                                    last, want.last, want.bus_byte));
      end
    end
  end

  // watchdog: a hung handshake or a missing byte ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sender: one number per call; returns right after the accepting edge
  // with start still high, so a following call can keep it high
  // --------------------------------------------------------------------------
  task automatic send_number(input logic [VALUE_W-1:0] v,
                             input logic [COL_W-1:0]   c,
                             input logic [ROW_W-1:0]   r);
    int gap;
    if (pace_gaps) begin
      if (burst_left == 0) begin
        // end of a burst: idle for a while, landing on any phase of the block
        burst_left = $urandom_range(1, MAX_BURST);
        gap = $urandom_range(1, MAX_GAP);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
    end
    start  <= 1'b1;
    value  <= v;
    column <= c;
    row    <= r;
    // transfer happens at the first edge that sees busy low
    do @(posedge clk); while (busy !== 1'b0);
    predict_bytes(v, c, r);
  endtask

  // hold off until every owed byte has come, then a few quiet cycles
  task automatic wait_all_bytes(input int extra);
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // random number with exactly ndig decimal digits, capped at the field range
  function automatic logic [VALUE_W-1:0] number_of_digits(input int ndig);
    longint unsigned lo;
    longint unsigned hi;
    lo = 1;
    for (int i = 1; i < ndig; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (ndig == 1) lo = 0;
    if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
    return VALUE_W'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // zero, the field maximum and the one-to-two, two-to-three and nine-to-ten digit edges
  task automatic test_value_extremes();
    logic [VALUE_W-1:0] edge_vals [$];
    edge_vals = '{31'd0, 31'd9, 31'd10, 31'd99, 31'd100, 31'd999999999,
                  31'd1000000000, 31'h7FFF_FFFF, 31'h4000_0000, 31'h2AAA_AAAA,
                  31'h5555_5555, 31'd1};
    foreach (edge_vals[i])
      send_number(edge_vals[i], COL_W'($urandom_range(0, 7)), ROW_W'(i % 4));
  endtask

  // every row, with the first and last column, so each row base and the
  // full column range show up in the command byte
  task automatic test_text_positions();
    for (int r = 0; r < 4; r++) begin
      send_number(VALUE_W'(r * 7), COL_W'(0), ROW_W'(r));
      send_number(VALUE_W'(12345 + r), COL_W'(7), ROW_W'(r));
    end
  endtask

  // bulk of the run: every digit count equally likely, random positions
  task automatic test_random_digit_counts(input int n);
    for (int i = 0; i < n; i++)
      send_number(number_of_digits($urandom_range(1, 10)),
                  COL_W'($urandom_range(0, 7)), ROW_W'($urandom_range(0, 3)));
  endtask

  // raw 31-bit values: mostly ten-digit numbers, every bit toggles
  task automatic test_random_full_range(input int n);
    for (int i = 0; i < n; i++)
      send_number(VALUE_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
  endtask

  // start held high throughout: the block never waits for the sender
  task automatic test_back_to_back(input int n);
    pace_gaps = 1'b0;
    for (int i = 0; i < n; i++)
      send_number(($urandom_range(0, 3) == 0) ? VALUE_W'($urandom)
                                              : number_of_digits($urandom_range(1, 4)),
                  COL_W'($urandom), ROW_W'($urandom));
    pace_gaps = 1'b1;
  endtask

  initial begin
    // synchronous reset, released on a rising edge
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_value_extremes();
    test_text_positions();
    // sender pauses until the block has emptied out completely
    wait_all_bytes(4);
    test_random_digit_counts(300);
    test_back_to_back(60);
    test_random_full_range(60);

    // all transfers in: wait for the owed bytes, then watch for strays
    wait_all_bytes(SETTLE_TICKS);
    if (pending_bytes.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
